FILE: rtl/line_follow_pid_steering_macros.svh
`ifndef LINE_FOLLOW_PID_STEERING_MACROS_SVH
`define LINE_FOLLOW_PID_STEERING_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LFPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define LFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication that is checked through reset as well.
`define LFPS_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lfps_pkg.sv
`default_nettype none

package lfps_pkg;

    localparam int SAMPLE_BITS_DEF = 8;
    localparam int GAIN_W          = 16;
    localparam int LEVEL_W         = 7;
    localparam int LIMIT_W         = 12;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 3;

    localparam int PRESENT_W = 8;
    localparam int DELTA_W   = 9;
    localparam int SUM_W     = 13;
    localparam int ERR_W     = 27;
    localparam int FRAC_W    = 17;
    localparam int STEER_W   = 9;

    localparam int M_TDATA_W = ((2 * LEVEL_W + STEER_W + 7) / 8) * 8;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;
    localparam logic signed [SUM_W-1:0] KI_Q16 = 13'sd2621;

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;

    typedef struct packed {
        logic [GAIN_W-1:0]  sensor_gain_q16;
        logic [LEVEL_W-1:0] black_level;
        logic [LEVEL_W-1:0] white_level;
        logic [LEVEL_W-1:0] cruise_speed;
        logic [LIMIT_W-1:0] integral_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        sensor_gain_q16: 16'd25559,
        black_level:     7'd77,
        white_level:     7'd7,
        cruise_speed:    7'd50,
        integral_limit:  12'd2500
    };

endpackage

`default_nettype wire

FILE: rtl/lfps_lane.sv
`default_nettype none

module lfps_lane #(
    parameter int SAMPLE_BITS = lfps_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            load,
    input  wire logic [SAMPLE_BITS-1:0]          sample,
    input  wire lfps_pkg::cfg_t                  cfg,
    output logic      [lfps_pkg::LEVEL_W-1:0]    level
);
    import lfps_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + GAIN_W;

    logic [PROD_W-1:0]      prod_reg;
    logic [SAMPLE_BITS-1:0] raw_lvl;
    logic [SAMPLE_BITS-1:0] black_ext;
    logic [SAMPLE_BITS-1:0] white_ext;
    logic [SAMPLE_BITS-1:0] mid_lvl;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= PROD_W'(sample) * PROD_W'(cfg.sensor_gain_q16);
        end
    end

    assign raw_lvl   = prod_reg[PROD_W-1:GAIN_W];
    assign black_ext = {{(SAMPLE_BITS-LEVEL_W){1'b0}}, cfg.black_level};
    assign white_ext = {{(SAMPLE_BITS-LEVEL_W){1'b0}}, cfg.white_level};

    // black test first, then white; a forced 100 can still drop to 0
    always_comb begin
        mid_lvl = (raw_lvl >= black_ext) ? SAMPLE_BITS'(LEVEL_FULL) : raw_lvl;
        level   = (mid_lvl <= white_ext) ? '0 : mid_lvl[LEVEL_W-1:0];
    end

endmodule

`default_nettype wire

FILE: rtl/lfps_pid.sv
`default_nettype none

module lfps_pid (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_fire,
    output logic                                    in_ready,
    input  wire logic [lfps_pkg::LEVEL_W-1:0]       left_level,
    input  wire logic [lfps_pkg::LEVEL_W-1:0]       right_level,
    input  wire lfps_pkg::cfg_t                     cfg,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [lfps_pkg::M_TDATA_W-1:0]     m_tdata
);
    import lfps_pkg::*;

    // stage flags: products ready, P ready, D/I ready, error ready
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic out_load;

    logic signed [PRESENT_W-1:0] present_reg, prev_reg, present_next;
    logic signed [DELTA_W-1:0]   delta_reg, delta_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic signed [SUM_W:0]       sum_wide, lim_wide;
    logic signed [ERR_W-1:0]     e_reg, e_next;

    logic                  neg;
    logic [ERR_W-1:0]      mag;
    logic [STEER_W-1:0]    whole;
    logic                  frac_nz;
    logic [STEER_W:0]      ceil_mag;
    logic [LEVEL_W-1:0]    reduced;
    logic [LEVEL_W-1:0]    ld_next, rd_next;
    logic [STEER_W-1:0]    shown_next;

    logic                  m_tvalid_reg;
    logic [LEVEL_W-1:0]    ld_reg, rd_reg;
    logic [STEER_W-1:0]    shown_reg;

    assign out_load = v4_reg && (!m_tvalid_reg || m_tready);
    assign in_ready = !(v1_reg || v2_reg || v3_reg) && (!v4_reg || out_load);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            prev_reg     <= '0;
            sum_reg      <= '0;
        end else begin
            v1_reg <= in_fire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg || (v4_reg && !out_load);
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (v2_reg) begin
                sum_reg  <= sum_next;
                prev_reg <= present_reg;
            end
        end
    end

    assign present_next = $signed({1'b0, right_level}) - $signed({1'b0, left_level});
    assign delta_next   = DELTA_W'(present_reg) - DELTA_W'(prev_reg);
    assign sum_wide     = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(present_reg);
    assign lim_wide     = $signed({2'b00, cfg.integral_limit});

    always_comb begin
        if (sum_wide < -lim_wide) begin
            sum_next = SUM_W'(-lim_wide);
        end else if (sum_wide > lim_wide) begin
            sum_next = SUM_W'(lim_wide);
        end else begin
            sum_next = SUM_W'(sum_wide);
        end
    end

    // error in units of 2^-17, final halving included
    assign e_next = (ERR_W'(present_reg) <<< 16) + (ERR_W'(delta_reg) <<< 15)
                  + ERR_W'(sum_reg) * ERR_W'(KI_Q16);

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            present_reg <= present_next;
        end
        if (v2_reg) begin
            delta_reg <= delta_next;
        end
        if (v3_reg) begin
            e_reg <= e_next;
        end
        if (out_load) begin
            ld_reg    <= ld_next;
            rd_reg    <= rd_next;
            shown_reg <= shown_next;
        end
    end

    always_comb begin
        neg      = e_reg[ERR_W-1];
        mag      = neg ? $unsigned(-e_reg) : $unsigned(e_reg);
        whole    = mag[FRAC_W+STEER_W-1:FRAC_W];
        frac_nz  = |mag[FRAC_W-1:0];
        ceil_mag = {1'b0, whole} + {{STEER_W{1'b0}}, frac_nz};
        reduced  = (ceil_mag >= (STEER_W+1)'(cfg.cruise_speed)) ? '0
                 : cfg.cruise_speed - ceil_mag[LEVEL_W-1:0];
        ld_next    = cfg.cruise_speed;
        rd_next    = cfg.cruise_speed;
        shown_next = '0;
        // magnitude below one: no steering
        if (|mag[ERR_W-1:FRAC_W]) begin
            if (neg) begin
                ld_next    = reduced;
                shown_next = -whole;
            end else begin
                rd_next    = reduced;
                shown_next = whole;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({shown_reg, rd_reg, ld_reg});

endmodule

`default_nettype wire

FILE: rtl/line_follow_pid_steering.sv
// Channel   Dir  Payload (low bits first)                        Handshake
// s_*       in   left_sample, right_sample                        s_tvalid/s_tready
// m_*       out  left_drive, right_drive, steer_error             m_tvalid/m_tready
// cfg_*     in   register index, write data                       cfg_we
//
// One transaction in gives one transaction out, through the lane product,
// P, D/I, error and output registers. A new transaction is not taken until
// the last leaves the four-stage product / P / D-I / error chain it walks alone.
// A finished result waits in the output register; the next transaction is
// taken as that register loads, so only an m_tready stall longer than the
// chain holds back s_tready. Reset (aresetn low, synchronous) restores the
// config registers and clears the valid flags, P history and the integral.
`default_nettype none

module line_follow_pid_steering #(
    parameter int SAMPLE_BITS = lfps_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // left_sample, right_sample
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // left_drive, right_drive, steer_error, zero fill
    output logic      [lfps_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    input  wire logic                                   cfg_we,
    input  wire logic [lfps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [lfps_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import lfps_pkg::*;

    cfg_t               cfg_reg;
    logic               s_fire;
    logic [LEVEL_W-1:0] left_level, right_level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SENSOR_GAIN:    cfg_reg.sensor_gain_q16 <= cfg_wdata;
                REG_BLACK_LEVEL:    cfg_reg.black_level     <= cfg_wdata[LEVEL_W-1:0];
                REG_WHITE_LEVEL:    cfg_reg.white_level     <= cfg_wdata[LEVEL_W-1:0];
                REG_CRUISE_SPEED:   cfg_reg.cruise_speed    <= cfg_wdata[LEVEL_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit  <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_fire = s_tvalid && s_tready;

    lfps_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
        .aclk   (aclk),
        .load   (s_fire),
        .sample (s_tdata[SAMPLE_BITS-1:0]),
        .cfg    (cfg_reg),
        .level  (left_level)
    );

    lfps_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
        .aclk   (aclk),
        .load   (s_fire),
        .sample (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .cfg    (cfg_reg),
        .level  (right_level)
    );

    lfps_pid u_pid (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (s_fire),
        .in_ready    (s_tready),
        .left_level  (left_level),
        .right_level (right_level),
        .cfg         (cfg_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/lfps_checker.sv
`default_nettype none
`include "line_follow_pid_steering_macros.svh"

module lfps_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [lfps_pkg::M_TDATA_W-1:0]     m_tdata
);
    import lfps_pkg::*;

    logic               s_fire;
    logic [LEVEL_W-1:0] ld, rd;
    logic [STEER_W-1:0] err;

    assign s_fire = s_tvalid && s_tready;
    assign ld     = m_tdata[LEVEL_W-1:0];
    assign rd     = m_tdata[2*LEVEL_W-1:LEVEL_W];
    assign err    = m_tdata[2*LEVEL_W+STEER_W-1:2*LEVEL_W];

    `LFPS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn, ##1 !m_tvalid, "result valid after reset")

    `LFPS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    `LFPS_ASSERT_NOW(a_steer_side, aclk, aresetn, m_tvalid, (err[STEER_W-1] ? (rd >= ld) : (ld >= rd)), "speed cut on wrong wheel")

    // s_tready stays low while the transaction is in the product, P and D/I stages
    `LFPS_ASSERT_NEXT(a_no_early, aclk, aresetn, s_fire, !s_tready[*3], "input taken again too soon")

endmodule

bind line_follow_pid_steering lfps_checker u_lfps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
